>>> sv/bzs_pkg.sv
package bzs_pkg;

  // Field and datapath widths
  localparam int unsigned SCORE_BITS = 16;
  localparam int unsigned SUM_BITS   = 48;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KEY_W      = 2 * BYTE_W;
  localparam int unsigned KEY_DEPTH  = 1 << KEY_W;
  localparam int unsigned REG_W      = 24;

  // Valid bits live in rows so that a clear sweep is short
  localparam int unsigned ROW_SEL_W  = 6;
  localparam int unsigned ROW_BITS   = 1 << ROW_SEL_W;
  localparam int unsigned ROW_W      = KEY_W - ROW_SEL_W;
  localparam int unsigned NUM_ROWS   = 1 << ROW_W;

  // Z-score arithmetic: diff holds score*256 - mean, one sign bit on top
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned DIFF_W     = SCORE_BITS + BYTE_W + 1;
  localparam int unsigned MUL_B_W    = REG_W + 1;
  localparam int unsigned PROD_W     = DIFF_W + MUL_B_W;
  localparam int unsigned Z_W        = PROD_W - FRAC_SHIFT;
  localparam int unsigned ADD_W      = Z_W + 1;
  localparam int unsigned WIDE_W     = SUM_BITS + 2;
  localparam int unsigned OVF_W      = WIDE_W - SUM_BITS + 1;

  // Command queue
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = Q_PTR_W + 1;

  // Configuration
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_Q8   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SD_Q16 = CFG_IDX_W'(1);
  localparam logic [REG_W-1:0] MEAN_RESET   = REG_W'(0);
  localparam logic [REG_W-1:0] INV_SD_RESET = REG_W'(65536);

  // Input action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_TEXT   = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_TEXT
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  key_first;
    logic [7:0]  key_second;
    logic [15:0] entry_score;
    logic [7:0]  text_byte;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] text_total;
    logic               found;
    logic               saturated;
  } out_item_t;

  // Classified command from the front end to the back end
  typedef struct packed {
    cmd_op_e               op;
    logic [KEY_W-1:0]      key;
    logic [SCORE_BITS-1:0] score;
    logic [1:0]            weight;
    logic                  last;
  } cmd_t;

endpackage

>>> sv/bzs_fifo.sv
module bzs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bzs_pkg::cmd_t  data_i,
  input  logic           pop_i,
  output bzs_pkg::cmd_t  data_o,
  output logic           full_o,
  output logic           empty_o
);

  bzs_pkg::cmd_t                 mem_q [bzs_pkg::Q_DEPTH];
  logic [bzs_pkg::Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [bzs_pkg::Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [bzs_pkg::Q_CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == bzs_pkg::Q_CNT_W'(bzs_pkg::Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/bzs_front.sv
module bzs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bzs_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  input  logic              sweep_busy_i,
  output logic              push_o,
  output bzs_pkg::cmd_t     cmd_o
);

  logic [bzs_pkg::BYTE_W-1:0] prev_q, prev_d;
  logic                       have_prev_q, have_prev_d;
  logic                       stopped_q, stopped_d;
  logic                       accept;
  logic [bzs_pkg::BYTE_W-1:0] cur;
  logic                       last;
  logic [1:0]                 weight;

  assign in_ready_o = !q_full_i && !sweep_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cur        = in_data_i.text_byte;
  assign last       = in_data_i.end_of_text;
  // one point for a high previous byte, one for a high current byte not last
  assign weight     = 2'(prev_q[bzs_pkg::BYTE_W-1])
                    + 2'(cur[bzs_pkg::BYTE_W-1] && !last);

  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    stopped_d   = stopped_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    cmd_o.op    = bzs_pkg::OP_TEXT;
    if (accept) begin
      unique case (in_data_i.action)
        bzs_pkg::ACT_CLEAR: begin
          push_o   = 1'b1;
          cmd_o.op = bzs_pkg::OP_CLEAR;
        end
        bzs_pkg::ACT_INSERT: begin
          push_o      = 1'b1;
          cmd_o.op    = bzs_pkg::OP_INSERT;
          cmd_o.key   = {in_data_i.key_first, in_data_i.key_second};
          cmd_o.score = in_data_i.entry_score[bzs_pkg::SCORE_BITS-1:0];
        end
        bzs_pkg::ACT_TEXT: begin
          if (!stopped_q) begin
            if (cur == '0) begin
              stopped_d = 1'b1;
            end else begin
              if (have_prev_q) begin
                cmd_o.weight = weight;
                cmd_o.key    = {prev_q, cur};
              end
              prev_d      = cur;
              have_prev_d = 1'b1;
            end
          end
          cmd_o.last = last;
          // drop bytes that neither look up nor close the text
          push_o     = last || (cmd_o.weight != '0);
          if (last) begin
            prev_d      = '0;
            have_prev_d = 1'b0;
            stopped_d   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      stopped_q   <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      stopped_q   <= stopped_d;
    end
  end

endmodule

>>> sv/bzs_back.sv
module bzs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  bzs_pkg::cmd_t             q_cmd_i,
  output logic                      q_pop_o,
  input  logic [bzs_pkg::REG_W-1:0] mean_q8_i,
  input  logic [bzs_pkg::REG_W-1:0] inv_sd_q16_i,
  output logic                      sweep_busy_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bzs_pkg::out_item_t        out_data_o
);

  localparam logic signed [bzs_pkg::SUM_BITS-1:0] SumMax =
    {1'b0, {(bzs_pkg::SUM_BITS-1){1'b1}}};
  localparam logic signed [bzs_pkg::SUM_BITS-1:0] SumMin =
    {1'b1, {(bzs_pkg::SUM_BITS-1){1'b0}}};

  // Memories
  logic [bzs_pkg::SCORE_BITS-1:0] score_mem [bzs_pkg::KEY_DEPTH];
  logic [bzs_pkg::ROW_BITS-1:0]   valid_mem [bzs_pkg::NUM_ROWS];

  // Sweep
  logic                        sweep_q, sweep_d;
  logic [bzs_pkg::ROW_W-1:0]   row_q, row_d;

  // Issue
  logic advance;
  logic pop_text, pop_insert, pop_clear;

  // Valid row write port
  logic                        vwe;
  logic [bzs_pkg::ROW_W-1:0]   vaddr;
  logic [bzs_pkg::ROW_BITS-1:0] vmask;
  logic [bzs_pkg::ROW_BITS-1:0] vdata;

  // Lookup stage
  logic                            s2_valid_q;
  logic [1:0]                      s2_weight_q;
  logic                            s2_last_q;
  logic [bzs_pkg::ROW_SEL_W-1:0]   s2_bit_q;
  logic [bzs_pkg::SCORE_BITS-1:0]  score_rd_q;
  logic [bzs_pkg::ROW_BITS-1:0]    vrow_rd_q;
  logic                            s2_hit;
  logic signed [bzs_pkg::DIFF_W-1:0]  diff;
  logic signed [bzs_pkg::MUL_B_W-1:0] inv_s;
  logic signed [bzs_pkg::PROD_W-1:0]  prod;

  // Accumulate stage
  logic                              s3_valid_q;
  logic                              s3_hit_q;
  logic [1:0]                        s3_weight_q;
  logic                              s3_last_q;
  logic signed [bzs_pkg::PROD_W-1:0] s3_prod_q;
  logic signed [bzs_pkg::Z_W-1:0]    z;
  logic signed [bzs_pkg::ADD_W-1:0]  addend;
  logic signed [bzs_pkg::WIDE_W-1:0] wide;
  logic [bzs_pkg::OVF_W-1:0]         upper;
  logic                              ovf;
  logic signed [bzs_pkg::SUM_BITS-1:0] sum_q, sum_d, sum_new;
  logic                              found_q, found_d, found_new;
  logic                              sat_q, sat_d, sat_new;

  // Output
  logic               out_valid_q, out_valid_d;
  bzs_pkg::out_item_t out_data_q;

  assign advance      = !out_valid_q || out_ready_i;
  assign q_pop_o      = !q_empty_i && advance && !sweep_q;
  assign pop_text     = q_pop_o && (q_cmd_i.op == bzs_pkg::OP_TEXT);
  assign pop_insert   = q_pop_o && (q_cmd_i.op == bzs_pkg::OP_INSERT);
  assign pop_clear    = q_pop_o && (q_cmd_i.op == bzs_pkg::OP_CLEAR);
  assign sweep_busy_o = sweep_q;

  // Sweep control: clear the valid rows in turn, without stalls, after reset and after each clear
  always_comb begin
    sweep_d = sweep_q;
    row_d   = row_q;
    if (sweep_q) begin
      row_d = row_q + 1'b1;
      if (row_q == bzs_pkg::ROW_W'(bzs_pkg::NUM_ROWS - 1)) begin
        sweep_d = 1'b0;
      end
    end else if (pop_clear) begin
      sweep_d = 1'b1;
      row_d   = '0;
    end
  end

  always_comb begin
    vwe   = 1'b0;
    vaddr = row_q;
    vmask = '1;
    vdata = '0;
    if (sweep_q) begin
      vwe = 1'b1;
    end else if (pop_insert) begin
      vwe   = 1'b1;
      vaddr = q_cmd_i.key[bzs_pkg::KEY_W-1:bzs_pkg::ROW_SEL_W];
      vmask = bzs_pkg::ROW_BITS'(1) << q_cmd_i.key[bzs_pkg::ROW_SEL_W-1:0];
      vdata = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_insert) begin
      score_mem[q_cmd_i.key] <= q_cmd_i.score;
    end
    if (pop_text) begin
      score_rd_q <= score_mem[q_cmd_i.key];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      for (int b = 0; b < bzs_pkg::ROW_BITS; b++) begin
        if (vmask[b]) begin
          valid_mem[vaddr][b] <= vdata[b];
        end
      end
    end
    if (pop_text) begin
      vrow_rd_q <= valid_mem[q_cmd_i.key[bzs_pkg::KEY_W-1:bzs_pkg::ROW_SEL_W]];
    end
  end

  // Lookup stage: select the valid bit, form the z-score product
  assign s2_hit = (s2_weight_q != '0) && vrow_rd_q[s2_bit_q];
  assign diff   = $signed({1'b0, score_rd_q, {bzs_pkg::BYTE_W{1'b0}}})
                - $signed({{(bzs_pkg::DIFF_W - bzs_pkg::REG_W){1'b0}}, mean_q8_i});
  assign inv_s  = $signed({1'b0, inv_sd_q16_i});
  assign prod   = diff * inv_s;

  // Accumulate stage: arithmetic shift, weight, saturating add
  assign z      = s3_prod_q[bzs_pkg::PROD_W-1:bzs_pkg::FRAC_SHIFT];
  assign addend = s3_weight_q[1] ? {z, 1'b0} : {z[bzs_pkg::Z_W-1], z};
  assign wide   = bzs_pkg::WIDE_W'(sum_q) + bzs_pkg::WIDE_W'(addend);
  assign upper  = wide[bzs_pkg::WIDE_W-1:bzs_pkg::SUM_BITS-1];
  assign ovf    = !((upper == '0) || (upper == '1));

  always_comb begin
    sum_new   = sum_q;
    found_new = found_q | s3_hit_q;
    sat_new   = sat_q;
    if (s3_hit_q) begin
      if (ovf) begin
        sum_new = wide[bzs_pkg::WIDE_W-1] ? SumMin : SumMax;
        sat_new = 1'b1;
      end else begin
        sum_new = wide[bzs_pkg::SUM_BITS-1:0];
      end
    end
  end

  always_comb begin
    sum_d       = sum_q;
    found_d     = found_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s3_valid_q && s3_last_q;
      if (s3_valid_q) begin
        if (s3_last_q) begin
          sum_d   = '0;
          found_d = 1'b0;
          sat_d   = 1'b0;
        end else begin
          sum_d   = sum_new;
          found_d = found_new;
          sat_d   = sat_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      row_q       <= '0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      sum_q       <= '0;
      found_q     <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_q     <= sweep_d;
      row_q       <= row_d;
      if (advance) begin
        s2_valid_q <= pop_text;
        s3_valid_q <= s2_valid_q;
      end
      sum_q       <= sum_d;
      found_q     <= found_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_text) begin
      s2_weight_q <= q_cmd_i.weight;
      s2_last_q   <= q_cmd_i.last;
      s2_bit_q    <= q_cmd_i.key[bzs_pkg::ROW_SEL_W-1:0];
    end
    if (advance) begin
      s3_hit_q    <= s2_hit;
      s3_weight_q <= s2_weight_q;
      s3_last_q   <= s2_last_q;
      s3_prod_q   <= prod;
    end
    if (advance && s3_valid_q && s3_last_q) begin
      out_data_q.text_total <= sum_new;
      out_data_q.found      <= found_new;
      out_data_q.saturated  <= sat_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/bigram_zscore_text_scorer_top.sv
// Bigram z-score text scorer.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one item a cycle while
// in_ready_o is high: clear the pair map, insert a pair score, or a text byte. Text
// bytes are scored in pairs (previous, current) against the map; the byte marked
// end_of_text yields one result item on the output channel (out_valid_o /
// out_ready_i / out_data_o) with the saturated Q.8 total and its flags.
// Configuration: cfg_we_i writes mean_q8 (index 0) or inv_sd_q16 (index 1);
// other indexes are ignored. Write only while the block is idle.
// Throughput: one insert or text item per cycle unless a clear sweep or a waiting
// result holds the queue, set by the single read port of the pair memories and one
// 25x25 multiply plus one 50-bit add per byte.
// Result path: queue, lookup stage, accumulate stage, out_valid_o register.
// Reset: a sweep clears the 1024 pair valid rows; in_ready_o stays low meanwhile.
// Each clear item starts the same sweep once it leaves the queue; in_ready_o is
// low during it and items behind the clear wait queued.
// Receiver stall: the back end holds while a result waits; the front keeps
// accepting until the four-entry queue fills.
module bigram_zscore_text_scorer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bzs_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bzs_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [bzs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bzs_pkg::REG_W-1:0]     cfg_wdata_i
);

  logic [bzs_pkg::REG_W-1:0] mean_q8_q;
  logic [bzs_pkg::REG_W-1:0] inv_sd_q16_q;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic          sweep_busy;
  bzs_pkg::cmd_t push_cmd;
  bzs_pkg::cmd_t head_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q8_q    <= bzs_pkg::MEAN_RESET;
      inv_sd_q16_q <= bzs_pkg::INV_SD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bzs_pkg::CFG_MEAN_Q8) begin
        mean_q8_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == bzs_pkg::CFG_INV_SD_Q16) begin
        inv_sd_q16_q <= cfg_wdata_i;
      end
    end
  end

  // Classify items and track the text position
  bzs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .q_full_i     (q_full),
    .sweep_busy_i (sweep_busy),
    .push_o       (q_push),
    .cmd_o        (push_cmd)
  );

  // Decouple the front from the back
  bzs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .pop_i   (q_pop),
    .data_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Update the map, look up pairs, accumulate and deliver results
  bzs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (q_pop),
    .mean_q8_i    (mean_q8_q),
    .inv_sd_q16_i (inv_sd_q16_q),
    .sweep_busy_o (sweep_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Never issue from the queue while valid rows are being cleared
  a_no_pop_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_busy |-> !q_pop)
    else $error("queue popped during clear sweep");

  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full queue");

  // A text with no pair found sums nothing
  a_nofind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      ((out_data_o.text_total == '0) && !out_data_o.saturated))
    else $error("nonzero total without found pair");

endmodule

>>> test/bigram_zscore_text_scorer_top_tb.sv
`timescale 1ns / 100ps

module bigram_zscore_text_scorer_top_tb;

  // Action code the block must ignore, and register indexes it must ignore
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [bzs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = bzs_pkg::CFG_IDX_W'(2);
  localparam logic [bzs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = bzs_pkg::CFG_IDX_W'(3);

  // Long enough for several clear sweeps that hold the input
  localparam int unsigned STALL_LIMIT   = 6000;
  // Room for the result path plus margin for items still in the queue
  localparam int unsigned SETTLE_CYCLES = 12;
  // 0xFF pairs at the largest z-score, each but the last adding twice the z-score
  localparam int unsigned FLOOD_LEN     = 24;

  // Running model of the pair map and the text scorer, plus the results it owes
  class bigram_ledger;
    bit                             pair_valid [bzs_pkg::KEY_DEPTH];
    logic [bzs_pkg::SCORE_BITS-1:0] pair_score [bzs_pkg::KEY_DEPTH];
    logic [bzs_pkg::REG_W-1:0]      mean_q8;
    logic [bzs_pkg::REG_W-1:0]      inv_sd_q16;
    logic [7:0]                     prev_byte;
    bit                             primed;
    bit                             halted;
    bit                             hit;
    bit                             clamped;
    longint                         run_sum;
    bzs_pkg::out_item_t             pending_totals [$];
    int unsigned                    mismatches;

    function new();
      mean_q8    = bzs_pkg::MEAN_RESET;
      inv_sd_q16 = bzs_pkg::INV_SD_RESET;
      mismatches = 0;
      restart_text();
    endfunction

    function void restart_text();
      prev_byte = 8'h00;
      primed    = 1'b0;
      halted    = 1'b0;
      hit       = 1'b0;
      clamped   = 1'b0;
      run_sum   = 0;
    endfunction

    function void set_regs(logic [bzs_pkg::REG_W-1:0] mean,
                           logic [bzs_pkg::REG_W-1:0] inv_sd);
      mean_q8    = mean;
      inv_sd_q16 = inv_sd;
    endfunction

    // Q.8 z-score, floor of the product shifted down
    function longint pair_zscore(logic [bzs_pkg::SCORE_BITS-1:0] score);
      longint diff;
      diff = longint'(score) * 256 - longint'(mean_q8);
      return (diff * longint'(inv_sd_q16)) >>> 16;
    endfunction

    function void add_clamped(longint z);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bzs_pkg::SUM_BITS - 1)) - 1;
      lo = -hi - 1;
      if (z > 0 && run_sum > hi - z) begin
        run_sum = hi;
        clamped = 1'b1;
      end else if (z < 0 && run_sum < lo - z) begin
        run_sum = lo;
        clamped = 1'b1;
      end else begin
        run_sum += z;
      end
    endfunction

    function void take_item(bzs_pkg::in_item_t it);
      logic [bzs_pkg::KEY_W-1:0] key;
      int                        weight;
      longint                    z;
      bzs_pkg::out_item_t        res;
      case (it.action)
        bzs_pkg::ACT_CLEAR: begin
          foreach (pair_valid[k]) pair_valid[k] = 1'b0;
        end
        bzs_pkg::ACT_INSERT: begin
          key             = {it.key_first, it.key_second};
          pair_score[key] = it.entry_score;
          pair_valid[key] = 1'b1;
        end
        bzs_pkg::ACT_TEXT: begin
          if (!halted) begin
            if (it.text_byte == 8'h00) begin
              halted = 1'b1;
            end else begin
              if (primed) begin
                key    = {prev_byte, it.text_byte};
                weight = int'(prev_byte[7]) + int'(it.text_byte[7] && !it.end_of_text);
                if (weight > 0 && pair_valid[key]) begin
                  z = pair_zscore(pair_score[key]);
                  repeat (weight) add_clamped(z);
                  hit = 1'b1;
                end
              end
              prev_byte = it.text_byte;
              primed    = 1'b1;
            end
          end
          if (it.end_of_text) begin
            res.text_total = run_sum[bzs_pkg::SUM_BITS-1:0];
            res.found      = hit;
            res.saturated  = clamped;
            pending_totals.push_back(res);
            restart_text();
          end
        end
        default: ;
      endcase
    endfunction

    function void match_result(bzs_pkg::out_item_t got);
      bzs_pkg::out_item_t want;
      if (pending_totals.size() == 0) begin
        $error("text_total: expected no item, got %0d", got.text_total);
        mismatches++;
        return;
      end
      want = pending_totals.pop_front();
      if (got.text_total !== want.text_total) begin
        $error("text_total: expected %0d, got %0d", want.text_total, got.text_total);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, got.found);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  // Every input starts at a known value
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  bzs_pkg::in_item_t             in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  bzs_pkg::out_item_t            out_data_o;
  logic                          cfg_we_i    = 1'b0;
  logic [bzs_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [bzs_pkg::REG_W-1:0]     cfg_wdata_i = '0;

  // Percent of cycles in which each side holds back
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 75;
  int unsigned stall_cycles  = 0;

  bigram_ledger board;

  bigram_zscore_text_scorer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: check each accepted item, then draw the ready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.match_result(out_data_o);
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: abandon the run once nothing has moved on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Item builders; fields the action does not use carry random bits
  function automatic bzs_pkg::in_item_t noise_item(logic [1:0] action);
    logic [63:0]       raw;
    bzs_pkg::in_item_t it;
    raw       = {$urandom, $urandom};
    it        = raw[$bits(bzs_pkg::in_item_t)-1:0];
    it.action = action;
    return it;
  endfunction

  function automatic bzs_pkg::in_item_t clear_item();
    return noise_item(bzs_pkg::ACT_CLEAR);
  endfunction

  function automatic bzs_pkg::in_item_t spare_item();
    return noise_item(ACT_SPARE);
  endfunction

  function automatic bzs_pkg::in_item_t insert_item(logic [7:0] first, logic [7:0] second,
                                                    logic [15:0] score);
    bzs_pkg::in_item_t it;
    it             = noise_item(bzs_pkg::ACT_INSERT);
    it.key_first   = first;
    it.key_second  = second;
    it.entry_score = score;
    return it;
  endfunction

  function automatic bzs_pkg::in_item_t text_item(logic [7:0] text_byte, logic last);
    bzs_pkg::in_item_t it;
    it             = noise_item(bzs_pkg::ACT_TEXT);
    it.text_byte   = text_byte;
    it.end_of_text = last;
    return it;
  endfunction

  // Small alphabet, mostly high bytes, so that text pairs keep landing on stored keys
  function automatic logic [7:0] common_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h01;
      1:       return 8'h41;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'h81;
      5:       return 8'hA5;
      6:       return 8'hC3;
      7:       return 8'hE9;
      8:       return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  // Offer one item, idling first at the current rate; leave valid high once accepted
  // so that a following item goes out back to back
  task automatic push_item(input bzs_pkg::in_item_t it);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      if (!lowered) in_valid_i <= 1'b0;
      lowered = 1'b1;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_item(it);
  endtask

  // Hold the sender until every owed result is in, then let the pipeline empty
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (board.pending_totals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers; optionally poke the unused indexes, which must change nothing
  task automatic program_regs(input logic [bzs_pkg::REG_W-1:0] mean,
                              input logic [bzs_pkg::REG_W-1:0] inv_sd,
                              input bit poke_spare);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bzs_pkg::CFG_MEAN_Q8;
    cfg_wdata_i <= mean;
    @(posedge clk_i);
    cfg_idx_i   <= bzs_pkg::CFG_INV_SD_Q16;
    cfg_wdata_i <= inv_sd;
    @(posedge clk_i);
    if (poke_spare) begin
      cfg_idx_i   <= CFG_SPARE_LO;
      cfg_wdata_i <= bzs_pkg::REG_W'($urandom);
      @(posedge clk_i);
      cfg_idx_i   <= CFG_SPARE_HI;
      cfg_wdata_i <= bzs_pkg::REG_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    board.set_regs(mean, inv_sd);
  endtask

  // One text of the given length: alphabet bytes, some random bytes, a few zero stops
  task automatic send_text(input int unsigned len);
    int unsigned pick;
    logic [7:0]  b;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) b = 8'h00;
      else if (pick < 20) b = 8'($urandom);
      else b = common_byte();
      push_item(text_item(b, i == len - 1));
    end
  endtask

  // Mostly map loads and texts over the alphabet, with rare clears and ignored actions.
  // Always close on a complete text so that its result marks the end of the phase.
  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    logic [15:0] score;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        push_item(clear_item());
        sent++;
      end else if (pick < 25) begin
        case ($urandom_range(0, 9))
          0:       score = 16'h0000;
          1:       score = 16'hFFFF;
          default: score = 16'($urandom);
        endcase
        if ($urandom_range(0, 99) < 85) begin
          push_item(insert_item(common_byte(), common_byte(), score));
        end else begin
          push_item(insert_item(8'($urandom), 8'($urandom), score));
        end
        sent++;
      end else if (pick < 28) begin
        push_item(spare_item());
      end else begin
        len = $urandom_range(1, 10);
        send_text(len);
        sent += len;
      end
    end
    send_text($urandom_range(1, 10));
  endtask

  // A run of 0xFF pairs, each but the last adding twice the z-score of the stored pair
  task automatic flood_text(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      push_item(text_item(8'hFF, i == len - 1));
    end
  endtask

  initial begin
    board = new();

    // Hold reset, then release it for good
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: mean of 100.0, unit deviation, unused indexes poked
    program_regs(24'h006400, bzs_pkg::INV_SD_RESET, 1'b1);
    push_item(clear_item());
    push_item(insert_item(8'hFF, 8'hFF, 16'hFFFF));
    push_item(insert_item(8'h80, 8'h81, 16'h0000));
    push_item(insert_item(8'h00, 8'h00, 16'h1234));
    push_item(insert_item(8'h7F, 8'h80, 16'h0064));
    push_item(insert_item(8'h81, 8'hFF, 16'h00FF));
    // Overwrite an existing pair
    push_item(insert_item(8'hFF, 8'hFF, 16'h8000));
    push_item(spare_item());
    // First byte adds nothing; weight one, then two, then one on the last byte
    push_item(text_item(8'h7F, 1'b0));
    push_item(text_item(8'h80, 1'b0));
    push_item(text_item(8'h81, 1'b0));
    push_item(text_item(8'hFF, 1'b1));
    // A text of one byte has no pair at all
    push_item(text_item(8'hFF, 1'b1));
    // Stored pair of low bytes carries zero weight
    push_item(insert_item(8'h01, 8'h01, 16'h7777));
    push_item(text_item(8'h01, 1'b0));
    push_item(text_item(8'h01, 1'b1));
    // A zero byte stops scoring; the bytes after it add nothing
    push_item(text_item(8'hFF, 1'b0));
    push_item(text_item(8'hFF, 1'b0));
    push_item(text_item(8'h00, 1'b0));
    push_item(text_item(8'hFF, 1'b0));
    push_item(text_item(8'hFF, 1'b1));
    // Zero as the last byte still yields a result
    push_item(text_item(8'hFF, 1'b0));
    push_item(text_item(8'h00, 1'b1));
    // After a clear nothing is found
    push_item(clear_item());
    push_item(text_item(8'hFF, 1'b0));
    push_item(text_item(8'hFF, 1'b1));
    quiesce();

    // Sender idles lightly, receiver heavily
    program_regs(bzs_pkg::REG_W'($urandom_range(0, 24'hFFFFFF)),
                 bzs_pkg::REG_W'($urandom_range(1, 24'h040000)), 1'b0);
    run_random(320);
    quiesce();
    program_regs(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    run_random(320);
    quiesce();

    // Swap the idle rates
    send_idle_pct = 75;
    recv_idle_pct = 26;
    program_regs(24'h000000, 24'h000000, 1'b0);
    run_random(320);
    quiesce();
    program_regs(bzs_pkg::REG_W'($urandom_range(0, 24'hFFFFFF)),
                 bzs_pkg::REG_W'($urandom_range(1, 24'hFFFFFF)), 1'b1);
    run_random(320);
    quiesce();

    // Neither side idles
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(bzs_pkg::REG_W'($urandom_range(0, 24'hFFFFFF)), bzs_pkg::INV_SD_RESET,
                 1'b0);
    run_random(540);
    quiesce();

    // Largest positive z-score on a run of mostly weight-two pairs
    program_regs(24'h000000, 24'hFFFFFF, 1'b0);
    push_item(insert_item(8'hFF, 8'hFF, 16'hFFFF));
    flood_text(FLOOD_LEN);
    quiesce();

    // Largest negative z-score on a run of mostly weight-two pairs
    program_regs(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    push_item(insert_item(8'hFF, 8'hFF, 16'h0000));
    flood_text(FLOOD_LEN);
    quiesce();

    if (board.mismatches == 0 && board.pending_totals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
